@@ rtl/core/pcl_pkg.sv @@
// shared types and constants of the palette colormap lookup
package pcl_pkg;

    // request kinds carried in tuser
    typedef enum logic [1:0] {
        REQ_MAP    = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_LENGTH = 2'd2
    } t_req;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_VALUE_MIN   = 3'd0,
        CFG_VALUE_MAX   = 3'd1,
        CFG_PAL_SELECT  = 3'd2,
        CFG_INVERT      = 3'd3,
        CFG_TRANSP_EN   = 3'd4,
        CFG_TRANSP_TOL  = 3'd5
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W = 3;

    // map request sequencer
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_RD   = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    // what the finished map request returns
    typedef enum logic [1:0] {
        KIND_COLOR = 2'd0,
        KIND_NAN   = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    localparam logic [7:0] COMP_MAX = 8'hFF;
    localparam logic [7:0] COMP_MIN = 8'h00;

endpackage

@@ rtl/core/pcl_ram.sv @@
// generic single-port-write, registered-read ram
module pcl_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/palette_colormap_lookup.sv @@
// top level: sample to rgba mapping through loaded palettes
// write and length requests: one per cycle while idle, applied at the accepting edge
// map request: accepted, then MUL, the DIV steps of the one-bit-per-cycle restoring divider, RD
//   and FIN; the result is registered on leaving FIN; next request accepted the cycle after
// nan and near-minimum requests: go straight to FIN, result registered on leaving FIN; a held color stalls
//   the final step. reset (synchronous, active low) restores configuration, lengths, state and valid, not entries
module palette_colormap_lookup #(
    parameter int unsigned NUM_PALETTES = 4,
    parameter int unsigned MAX_COLORS   = 256,
    parameter int unsigned SAMPLE_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // sample, sample_is_nan, palette_id, entry_index, red_in, green_in, blue_in, length_in
    input  logic [((SAMPLE_BITS+44+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic [1:0]             s_axis_tuser,
    // color stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // red, green, blue, alpha
    output logic [31:0]            m_axis_tdata,
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [pcl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SAMPLE_BITS-1:0] i_cfg_data
);

    localparam int unsigned SB     = SAMPLE_BITS;
    localparam int unsigned SB1    = SAMPLE_BITS + 1;
    localparam int unsigned IDX_W  = $clog2(MAX_COLORS);
    localparam int unsigned LEN_W  = $clog2(MAX_COLORS + 1);
    localparam int unsigned PAL_W  = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
    localparam int unsigned DEPTH  = NUM_PALETTES * MAX_COLORS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int unsigned NUM_W  = IDX_W + SB;

    // request fields, lowest first in tdata
    logic signed [SB-1:0] w_sample;
    logic                 w_nan;
    logic [1:0]           w_pid;
    logic [7:0]           w_entry;
    logic [7:0]           w_red_in;
    logic [7:0]           w_green_in;
    logic [7:0]           w_blue_in;
    logic [8:0]           w_length_in;

    assign w_sample    = s_axis_tdata[SB-1:0];
    assign w_nan       = s_axis_tdata[SB];
    assign w_pid       = s_axis_tdata[SB+2:SB+1];
    assign w_entry     = s_axis_tdata[SB+10:SB+3];
    assign w_red_in    = s_axis_tdata[SB+18:SB+11];
    assign w_green_in  = s_axis_tdata[SB+26:SB+19];
    assign w_blue_in   = s_axis_tdata[SB+34:SB+27];
    assign w_length_in = s_axis_tdata[SB+43:SB+35];

    // configuration registers
    logic signed [SB-1:0] r_val_min;
    logic signed [SB-1:0] r_val_max;
    logic [1:0]           r_pal_sel;
    logic                 r_invert;
    logic                 r_transp_en;
    logic [7:0]           r_transp_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_min    <= '0;
            r_val_max    <= SB'(32'sd32767);
            r_pal_sel    <= '0;
            r_invert     <= 1'b0;
            r_transp_en  <= 1'b0;
            r_transp_tol <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (pcl_pkg::t_cfg_idx'(i_cfg_index))
                pcl_pkg::CFG_VALUE_MIN:  r_val_min    <= i_cfg_data;
                pcl_pkg::CFG_VALUE_MAX:  r_val_max    <= i_cfg_data;
                pcl_pkg::CFG_PAL_SELECT: r_pal_sel    <= i_cfg_data[1:0];
                pcl_pkg::CFG_INVERT:     r_invert     <= i_cfg_data[0];
                pcl_pkg::CFG_TRANSP_EN:  r_transp_en  <= i_cfg_data[0];
                pcl_pkg::CFG_TRANSP_TOL: r_transp_tol <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    pcl_pkg::t_state      r_state;
    pcl_pkg::t_kind       r_kind;
    logic [SB-1:0]        r_off;       // clamped sample minus minimum
    logic [SB-1:0]        r_div;       // span, never zero
    logic [IDX_W-1:0]     r_lenm1;     // palette length minus one
    logic [PAL_W-1:0]     r_sel;
    logic [SB-1:0]        r_rem;
    logic [IDX_W-1:0]     r_nlo;       // numerator bits still to shift in
    logic [IDX_W-1:0]     r_quot;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;

    // per-palette length, reset to one
    logic [LEN_W-1:0]     r_pal_len [NUM_PALETTES];

    logic w_accept;
    logic w_out_free;
    assign s_axis_tready = (r_state == pcl_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // range checks for write and length requests
    logic             w_pid_ok;
    logic             w_entry_ok;
    logic [PAL_W-1:0] w_pid_x;
    logic [12:0]      w_len13;
    logic [LEN_W-1:0] w_len_sat;

    assign w_pid_ok   = ({3'b000, w_pid} < 5'(NUM_PALETTES));
    assign w_entry_ok = ({5'b00000, w_entry} < 13'(MAX_COLORS));
    assign w_pid_x    = PAL_W'(w_pid);
    assign w_len13    = {4'b0000, w_length_in};

    always_comb begin
        if (w_len13 == 13'd0) begin
            w_len_sat = LEN_W'(1);
        end else if (w_len13 > 13'(MAX_COLORS)) begin
            w_len_sat = LEN_W'(MAX_COLORS);
        end else begin
            w_len_sat = LEN_W'(w_len13);
        end
    end

    // map request front end: clamp, span, transparency test
    logic [PAL_W-1:0]      w_sel;
    logic signed [SB1-1:0] w_lo_x;
    logic signed [SB1-1:0] w_hi_x;
    logic signed [SB1-1:0] w_v_x;
    logic signed [SB1-1:0] w_v_c;
    logic signed [SB1-1:0] w_dv;
    logic [SB1-1:0]        w_dist;
    logic                  w_rev;
    logic                  w_transp;

    assign w_sel = ({3'b000, r_pal_sel} >= 5'(NUM_PALETTES)) ? PAL_W'(NUM_PALETTES - 1)
                                                              : PAL_W'(r_pal_sel);
    assign w_lo_x = {r_val_min[SB-1], r_val_min};
    assign w_v_x  = {w_sample[SB-1], w_sample};
    // equal bounds widen the span to one
    assign w_hi_x = (r_val_max == r_val_min) ? w_lo_x + SB1'(1) : {r_val_max[SB-1], r_val_max};
    assign w_rev  = (w_hi_x < w_lo_x);

    always_comb begin
        w_v_c = w_v_x;
        if (w_v_c > w_hi_x) begin
            w_v_c = w_hi_x;
        end
        if (w_v_c < w_lo_x) begin
            w_v_c = w_lo_x;
        end
    end

    assign w_dv     = w_v_x - w_lo_x;
    assign w_dist   = w_dv[SB1-1] ? SB1'(-w_dv) : SB1'(w_dv);
    assign w_transp = r_transp_en && (w_dist < SB1'(r_transp_tol));

    // product and divider step
    logic [NUM_W-1:0] w_prod;
    logic [SB:0]      w_trial;
    logic             w_qbit;
    assign w_prod  = NUM_W'(r_lenm1) * NUM_W'(r_off);
    assign w_trial = {r_rem, r_nlo[IDX_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_div});

    // palette addressing
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [IDX_W-1:0]  w_index;
    logic [23:0]       w_rdata;

    assign w_wr_en = w_accept && (pcl_pkg::t_req'(s_axis_tuser) == pcl_pkg::REQ_WRITE)
                     && w_pid_ok && w_entry_ok;
    assign w_waddr = ADDR_W'(w_pid_x) * ADDR_W'(MAX_COLORS) + ADDR_W'(w_entry);
    assign w_index = r_invert ? (r_lenm1 - r_quot) : r_quot;
    assign w_raddr = ADDR_W'(r_sel) * ADDR_W'(MAX_COLORS) + ADDR_W'(w_index);

    pcl_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_waddr),
        .i_wdata ({w_red_in, w_green_in, w_blue_in}),
        .i_re    (r_state == pcl_pkg::ST_RD),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // palette lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PALETTES; p++) begin
                r_pal_len[p] <= LEN_W'(1);
            end
        end else if (w_accept && (pcl_pkg::t_req'(s_axis_tuser) == pcl_pkg::REQ_LENGTH)
                     && w_pid_ok) begin
            r_pal_len[w_pid_x] <= w_len_sat;
        end
    end

    // map sequencer: accept, multiply, divide, read, deliver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcl_pkg::ST_IDLE;
        end else begin
            unique case (r_state)
                pcl_pkg::ST_IDLE: begin
                    if (w_accept && (pcl_pkg::t_req'(s_axis_tuser) == pcl_pkg::REQ_MAP)) begin
                        if (w_nan || w_transp) begin
                            r_state <= pcl_pkg::ST_FIN;
                        end else begin
                            r_state <= pcl_pkg::ST_MUL;
                        end
                    end
                end
                pcl_pkg::ST_MUL: r_state <= pcl_pkg::ST_DIV;
                pcl_pkg::ST_DIV: begin
                    if (r_cnt == CNT_W'(IDX_W - 1)) begin
                        r_state <= pcl_pkg::ST_RD;
                    end
                end
                pcl_pkg::ST_RD:  r_state <= pcl_pkg::ST_FIN;
                pcl_pkg::ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= pcl_pkg::ST_IDLE;
                    end
                end
                default: r_state <= pcl_pkg::ST_IDLE;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pcl_pkg::ST_IDLE: begin
                r_kind  <= w_nan ? pcl_pkg::KIND_NAN
                         : (w_transp ? pcl_pkg::KIND_CLEAR : pcl_pkg::KIND_COLOR);
                r_off   <= w_rev ? '0 : SB'(w_v_c - w_lo_x);
                r_div   <= w_rev ? SB'(1) : SB'(w_hi_x - w_lo_x);
                r_lenm1 <= IDX_W'(r_pal_len[w_sel] - LEN_W'(1));
                r_sel   <= w_sel;
            end
            pcl_pkg::ST_MUL: begin
                // product stays below span << index bits, so top part is below span
                r_rem  <= w_prod[NUM_W-1:IDX_W];
                r_nlo  <= w_prod[IDX_W-1:0];
                r_quot <= '0;
                r_cnt  <= '0;
            end
            pcl_pkg::ST_DIV: begin
                r_rem  <= w_qbit ? SB'(w_trial - {1'b0, r_div}) : SB'(w_trial);
                r_nlo  <= IDX_W'({r_nlo, 1'b0});
                r_quot <= IDX_W'({r_quot, w_qbit});
                r_cnt  <= r_cnt + CNT_W'(1);
            end
            default: ;
        endcase
    end

    // output register parts the sequencer from the color stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == pcl_pkg::ST_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == pcl_pkg::ST_FIN) && w_out_free) begin
            unique case (r_kind)
                pcl_pkg::KIND_NAN:
                    r_out_data <= {pcl_pkg::COMP_MAX, pcl_pkg::COMP_MIN,
                                   pcl_pkg::COMP_MIN, pcl_pkg::COMP_MAX};
                pcl_pkg::KIND_CLEAR:
                    r_out_data <= {pcl_pkg::COMP_MIN, pcl_pkg::COMP_MIN,
                                   pcl_pkg::COMP_MIN, pcl_pkg::COMP_MIN};
                default:
                    r_out_data <= {pcl_pkg::COMP_MAX, w_rdata[7:0],
                                   w_rdata[15:8], w_rdata[23:16]};
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // divider remainder stays below the span
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcl_pkg::ST_DIV) |-> (r_rem < r_div))
        else $error("divider remainder not below span");

    // quotient never points past the palette end
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcl_pkg::ST_RD) |-> (r_quot <= r_lenm1))
        else $error("palette index beyond length");

    // a new result only comes out of the delivery state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == pcl_pkg::ST_FIN))
        else $error("result without finished map request");
`endif

endmodule
